/* design/bba_pkg.sv */
package bba_pkg;

    localparam int BLOCK_W     = 12;
    localparam int REG_W       = 13;
    localparam int WORD_BITS   = 64;
    localparam int BIT_IDX_W   = 6;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOTAL_BLOCKS    = 2'd0,
        REG_RESERVED_BLOCKS = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_BLOCKS = 2'd1,
        ST_DOUBLE_FREE   = 2'd2,
        ST_OUT_OF_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic               mode;
        logic [BLOCK_W-1:0] block_number;
    } req_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] allocated_block;
        status_t            status;
    } rsp_t;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] idx;
    } ffz_result_t;

endpackage

/* design/bba_ram.sv */
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/bba_ffz.sv */
// Find the lowest clear bit of one bitmap word: pick the lowest byte with a
// clear bit, then the lowest clear bit inside it.
module bba_ffz (
    input  logic [bba_pkg::WORD_BITS-1:0] word,
    output bba_pkg::ffz_result_t          result
);

    localparam int GROUPS = bba_pkg::WORD_BITS / 8;

    logic [GROUPS-1:0] grp_free;
    logic [2:0]        grp_sel;
    logic [7:0]        grp_bits;
    logic [2:0]        bit_sel;

    always_comb begin
        grp_sel  = '0;
        bit_sel  = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp_free[g] = ~&word[g*8 +: 8];
        end
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_free[g]) begin
                grp_sel = 3'(g);
            end
        end
        grp_bits = word[{grp_sel, 3'b000} +: 8];
        for (int b = 7; b >= 0; b--) begin
            if (!grp_bits[b]) begin
                bit_sel = 3'(b);
            end
        end
        result.found = |grp_free;
        result.idx   = {grp_sel, bit_sel};
    end

endmodule

/* design/bitmap_block_allocator.sv */
// Flow: an allocate starts a scan that reads one bitmap word at a time
// (up to the smaller of MAX_BLOCKS and 4096 over 64, rounded up; 64 words at the
// default); a free reads and checks its single word; a request rejected on range
// answers in the cycle after acceptance.
// Throughput: one request at a time; the word scan through the single bitmap RAM
// read port and the shared find-first-zero unit sets the rate.
// Reset: synchronous, active low; all blocks free, total 4096, reserved 0.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  bba_pkg::req_t                       s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output bba_pkg::rsp_t                       m_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bba_pkg::REG_W-1:0]           cfg_data
);

    // Block numbers are 12 bits wide, so anything past 4096 is unreachable.
    localparam int BLOCK_LIMIT = 1 << bba_pkg::BLOCK_W;
    localparam int EFF_MAX     = (MAX_BLOCKS < BLOCK_LIMIT) ? MAX_BLOCKS : BLOCK_LIMIT;
    localparam int MAP_WORDS   = (EFF_MAX + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int WORD_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW          = bba_pkg::BIT_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [bba_pkg::REG_W-1:0] total_reg;
    logic [bba_pkg::REG_W-1:0] reserved_reg;

    // Request context
    logic                 mode_reg;
    logic [WORD_AW-1:0]   w_reg, w_next;
    logic [IW-1:0]        blk_lo_reg;

    // Per-word valid bits: a word never written reads as all free.
    logic [MAP_WORDS-1:0] wvalid_reg;

    // Result register
    logic                 m_valid_reg;
    bba_pkg::rsp_t        m_data_reg;

    // Derived limits
    logic [bba_pkg::REG_W-1:0] eff_total;
    logic [bba_pkg::REG_W-1:0] last_idx;
    logic [WORD_AW-1:0]        start_w;
    logic [WORD_AW-1:0]        last_w;
    logic [WORD_AW-1:0]        blk_w;
    logic                      none_alloc;
    logic                      blk_bad;

    // Datapath
    logic [bba_pkg::WORD_BITS-1:0] rd_data;
    logic [bba_pkg::WORD_BITS-1:0] word_eff;
    logic [bba_pkg::WORD_BITS-1:0] lo_mask;
    logic [bba_pkg::WORD_BITS-1:0] hi_mask;
    logic [bba_pkg::WORD_BITS-1:0] masked;
    logic [bba_pkg::WORD_BITS-1:0] wr_data;
    bba_pkg::ffz_result_t          ffz;
    logic                          wr_en;
    logic                          free_bit;
    logic                          s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Clamp the total to what the bitmap can hold.
    assign eff_total  = (total_reg > bba_pkg::REG_W'(EFF_MAX)) ?
                        bba_pkg::REG_W'(EFF_MAX) : total_reg;
    assign last_idx   = eff_total - 1'b1;
    assign start_w    = reserved_reg[IW +: WORD_AW];
    assign last_w     = last_idx[IW +: WORD_AW];
    assign blk_w      = s_data.block_number[IW +: WORD_AW];
    assign none_alloc = (reserved_reg >= eff_total);
    assign blk_bad    = ({1'b0, s_data.block_number} >= eff_total) ||
                        ({1'b0, s_data.block_number} < reserved_reg);

    // Scan word selection: the read issued this cycle returns next cycle.
    always_comb begin
        w_next     = w_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_data.mode == bba_pkg::MODE_ALLOC) begin
                        w_next = start_w;
                        if (!none_alloc) state_next = S_EVAL;
                    end else begin
                        w_next = blk_w;
                        if (!blk_bad) state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (mode_reg == bba_pkg::MODE_ALLOC && !ffz.found && w_reg != last_w) begin
                    // advance to the next word, stay in the scan
                    w_next = WORD_AW'(w_reg + 1'b1);
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    bba_ram #(
        .WIDTH (bba_pkg::WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WORD_AW)
    ) u_map (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (w_reg),
        .wdata (wr_data),
        .raddr (w_next),
        .rdata (rd_data)
    );

    // Treat reserved blocks and blocks past the total as used.
    always_comb begin
        word_eff = wvalid_reg[w_reg] ? rd_data : '0;
        lo_mask  = '0;
        hi_mask  = '0;
        if (w_reg == start_w) begin
            lo_mask = (bba_pkg::WORD_BITS'(1) << reserved_reg[IW-1:0]) - 1'b1;
        end
        if (w_reg == last_w) begin
            hi_mask = ~((bba_pkg::WORD_BITS'(2) << last_idx[IW-1:0]) - 1'b1);
        end
        masked = word_eff | lo_mask | hi_mask;
    end

    bba_ffz u_ffz (
        .word   (masked),
        .result (ffz)
    );

    assign free_bit = word_eff[blk_lo_reg];

    always_comb begin
        if (mode_reg == bba_pkg::MODE_ALLOC) begin
            wr_en   = (state_reg == S_EVAL) && ffz.found;
            wr_data = word_eff | (bba_pkg::WORD_BITS'(1) << ffz.idx);
        end else begin
            wr_en   = (state_reg == S_EVAL) && free_bit;
            wr_data = word_eff & ~(bba_pkg::WORD_BITS'(1) << blk_lo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            total_reg    <= bba_pkg::REG_W'(BLOCK_LIMIT);
            reserved_reg <= '0;
            wvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bba_pkg::REG_TOTAL_BLOCKS:    total_reg    <= cfg_data;
                    bba_pkg::REG_RESERVED_BLOCKS: reserved_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (wr_en) begin
                wvalid_reg[w_reg] <= 1'b1;
            end

            // Drop the result once taken; load a new one when the request ends.
            if ((s_fire && state_next == S_IDLE) ||
                (state_reg == S_EVAL && state_next == S_IDLE)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and request context: no reset needed.
    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        if (s_fire) begin
            mode_reg   <= s_data.mode;
            blk_lo_reg <= s_data.block_number[IW-1:0];
            if (s_data.mode == bba_pkg::MODE_ALLOC) begin
                m_data_reg.allocated_block <= '0;
                m_data_reg.status          <= bba_pkg::ST_OUT_OF_BLOCKS;
            end else begin
                m_data_reg.allocated_block <= '0;
                m_data_reg.status          <= bba_pkg::ST_OUT_OF_RANGE;
            end
        end
        if (state_reg == S_EVAL) begin
            if (mode_reg == bba_pkg::MODE_ALLOC) begin
                if (ffz.found) begin
                    m_data_reg.allocated_block <= bba_pkg::BLOCK_W'({w_reg, ffz.idx});
                    m_data_reg.status          <= bba_pkg::ST_OK;
                end else begin
                    m_data_reg.allocated_block <= '0;
                    m_data_reg.status          <= bba_pkg::ST_OUT_OF_BLOCKS;
                end
            end else begin
                m_data_reg.allocated_block <= '0;
                m_data_reg.status <= free_bit ? bba_pkg::ST_OK : bba_pkg::ST_DOUBLE_FREE;
            end
        end
    end

    // Only a successful allocate carries a nonzero block number.
    a_block_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != bba_pkg::ST_OK) |-> (m_data.allocated_block == '0))
        else $error("nonzero block number on an error result");

    // The scan never runs past the last managed word.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && mode_reg == bba_pkg::MODE_ALLOC) |-> (w_reg <= last_w))
        else $error("bitmap scan past the last word");

    // An accepted request either starts a scan or answers at once.
    a_accept_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_EVAL || m_valid_reg))
        else $error("accepted request neither scanning nor answered");

    // The bitmap is written only while a request is being evaluated.
    a_write_in_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_EVAL && !m_valid_reg))
        else $error("bitmap write outside evaluation");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_BLOCKS   = 4096;
    // Blocks reachable: bounded by the parameter and by the 12-bit block field.
    localparam int MAP_SIZE     = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;

    // Index past the two registers; a write to it must change nothing.
    localparam logic [bba_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd2;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // One line of the directed plan: either a request or a register write.
    typedef struct packed {
        row_kind_t                       kind;
        bba_pkg::req_t                   req;
        bit                              typed;
        bba_pkg::rsp_t                   rsp;
        logic [bba_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [bba_pkg::REG_W-1:0]       reg_value;
    } plan_row_t;

    // Response typed into the plan, carried alongside each offered request.
    typedef struct packed {
        bit            typed;
        bba_pkg::rsp_t rsp;
    } pin_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    bba_pkg::req_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    bba_pkg::rsp_t                   m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bba_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bba_pkg::REG_W-1:0]       cfg_data;

    // Shadow of the allocator: usage bits and the two registers.
    bit   [MAP_SIZE-1:0]             usage_map;
    logic [bba_pkg::REG_W-1:0]       map_total;
    logic [bba_pkg::REG_W-1:0]       map_reserved;

    bba_pkg::rsp_t                   due_rsp_q[$];
    pin_t                            typed_rsp_q[$];
    plan_row_t                       plan[$];
    int unsigned                     errors;

    // Handshake between stimulus and the response sink.
    bit                              rx_jitter;
    bit                              hold_off_req;
    bit                              hold_off_done;

    bitmap_block_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Ends a hung run.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Apply one request to the shadow bitmap and return the response it earns.
    // Allocate: first clear bit from reserved up to the clamped total.
    // Free: range and reserved checks come before the double-free check.
    function automatic bba_pkg::rsp_t model_request(input bba_pkg::req_t r);
        bba_pkg::rsp_t o;
        int unsigned   lim;
        int unsigned   b;
        bit            found;
        lim = (map_total > MAP_SIZE) ? MAP_SIZE : map_total;
        o.allocated_block = '0;
        if (r.mode == bba_pkg::MODE_ALLOC) begin
            o.status = bba_pkg::ST_OUT_OF_BLOCKS;
            found = 1'b0;
            b = map_reserved;
            while (!found && b < lim) begin
                if (!usage_map[b[bba_pkg::BLOCK_W-1:0]]) begin
                    usage_map[b[bba_pkg::BLOCK_W-1:0]] = 1'b1;
                    o.allocated_block = b[bba_pkg::BLOCK_W-1:0];
                    o.status = bba_pkg::ST_OK;
                    found = 1'b1;
                end
                b++;
            end
        end else if (r.block_number >= lim || r.block_number < map_reserved) begin
            o.status = bba_pkg::ST_OUT_OF_RANGE;
        end else if (!usage_map[r.block_number]) begin
            o.status = bba_pkg::ST_DOUBLE_FREE;
        end else begin
            usage_map[r.block_number] = 1'b0;
            o.status = bba_pkg::ST_OK;
        end
        return o;
    endfunction

    // Scoreboard: check responses, track register writes, predict on accept.
    always @(posedge aclk) begin : scoreboard
        bba_pkg::rsp_t exp_rsp;
        bba_pkg::rsp_t got;
        pin_t          pin;
        if (!aresetn) begin
            usage_map    = '0;
            map_total    = 13'd4096;
            map_reserved = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_rsp_q.size() == 0) begin
                    errors++;
                    $display("%0t: response with nothing outstanding: expected none, %s",
                             $time, $sformatf("actual %0d/%0d",
                                              m_data.allocated_block, m_data.status));
                end else begin
                    exp_rsp = due_rsp_q.pop_front();
                    if (m_data.allocated_block !== exp_rsp.allocated_block) begin
                        errors++;
                        $display("%0t: allocated_block expected %0d actual %0d",
                                 $time, exp_rsp.allocated_block, m_data.allocated_block);
                    end
                    if (m_data.status !== exp_rsp.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rsp.status, m_data.status);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bba_pkg::REG_TOTAL_BLOCKS:    map_total = cfg_data;
                    bba_pkg::REG_RESERVED_BLOCKS: map_reserved = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                // Always advance the shadow; a typed response overrides its answer.
                got = model_request(s_data);
                pin = typed_rsp_q.pop_front();
                due_rsp_q.push_back(pin.typed ? pin.rsp : got);
            end
        end
    end

    // Response sink: short random stalls, plus one long hold-off that lets the
    // block fill and push back on the request side.
    initial begin : sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                hold_off_done = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic void plan_req(input bba_pkg::mode_t m, input int unsigned blk,
                                     input bit typed, input int unsigned got,
                                     input bba_pkg::status_t st);
        plan_row_t row;
        row = '0;
        row.kind                = ROW_REQ;
        row.req.mode            = m;
        row.req.block_number    = blk[bba_pkg::BLOCK_W-1:0];
        row.typed               = typed;
        row.rsp.allocated_block = got[bba_pkg::BLOCK_W-1:0];
        row.rsp.status          = st;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(input logic [bba_pkg::CFG_INDEX_W-1:0] idx,
                                     input int unsigned val);
        plan_row_t row;
        row = '0;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = val[bba_pkg::REG_W-1:0];
        plan.push_back(row);
    endfunction

    // Free target: mostly inside the live range, sometimes just past either
    // end of it, sometimes anywhere in the 12-bit field.
    function automatic logic [bba_pkg::BLOCK_W-1:0] pick_victim(
        input logic [bba_pkg::REG_W-1:0] tot,
        input logic [bba_pkg::REG_W-1:0] rsv);
        int unsigned lim;
        int unsigned sel;
        int unsigned v;
        lim = (tot > MAP_SIZE) ? MAP_SIZE : tot;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            v = $urandom;
        else if (sel == 1)
            v = lim;
        else if (sel == 2)
            v = rsv - 1;
        else if (lim > rsv)
            v = $urandom_range(rsv, lim - 1);
        else
            v = $urandom;
        return v[bba_pkg::BLOCK_W-1:0];
    endfunction

    // Offer one request and hold it until accepted. Valid is left high on
    // return so a back-to-back request needs only one assignment.
    task automatic offer(input bba_pkg::req_t r, input bit typed, input bba_pkg::rsp_t rsp);
        pin_t pin;
        pin.typed = typed;
        pin.rsp   = rsp;
        typed_rsp_q.push_back(pin);
        cfg_valid <= 1'b0;
        s_data    <= r;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic gap(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Write a register once every outstanding request has been answered.
    // Every request earns a response, so an empty queue means an idle block.
    task automatic write_reg(input logic [bba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bba_pkg::REG_W-1:0] val);
        s_valid <= 1'b0;
        while (due_rsp_q.size() != 0 || typed_rsp_q.size() != 0) @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // One random stretch at a fixed setting. Requests alternate between
    // allocate-heavy and free-heavy runs of 16 so the map fills and drains;
    // idling switches on and off in runs of 32.
    task automatic run_phase(input logic [bba_pkg::REG_W-1:0] tot,
                             input logic [bba_pkg::REG_W-1:0] rsv,
                             input int unsigned n, input int unsigned fill_pct,
                             input bit idle);
        bba_pkg::req_t r;
        bit            quiet;
        int unsigned   rnd;
        write_reg(bba_pkg::REG_TOTAL_BLOCKS, tot);
        write_reg(bba_pkg::REG_RESERVED_BLOCKS, rsv);
        for (int i = 0; i < n; i++) begin
            quiet = !idle || (((i >> 5) & 1) != 0);
            rx_jitter = !quiet;
            if (!quiet && $urandom_range(0, 4) == 0)
                gap($urandom_range(1, 8));
            rnd = $urandom_range(0, 99);
            if (rnd < ((((i >> 4) & 1) == 0) ? fill_pct : 30)) begin
                r.mode = bba_pkg::MODE_ALLOC;
                rnd = $urandom;
                // Block number is don't-care on allocate; randomize it anyway.
                r.block_number = rnd[bba_pkg::BLOCK_W-1:0];
            end else begin
                r.mode = bba_pkg::MODE_FREE;
                r.block_number = pick_victim(tot, rsv);
            end
            offer(r, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int unsigned tot;
        int unsigned rsv;
        errors        = 0;
        rx_jitter     = 1'b0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan, starting from reset: total 4096, reserved 0, all free.
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 1,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_FREE,  0,    1, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_FREE,  0,    1, 0,    bba_pkg::ST_DOUBLE_FREE);
        plan_req(bba_pkg::MODE_ALLOC, 4095, 1, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_FREE,  4095, 1, 0,    bba_pkg::ST_DOUBLE_FREE);
        // Oversized total clamps to the 12-bit range.
        plan_cfg(bba_pkg::REG_TOTAL_BLOCKS, 8191);
        plan_req(bba_pkg::MODE_FREE,  4095, 1, 0,    bba_pkg::ST_DOUBLE_FREE);
        plan_req(bba_pkg::MODE_ALLOC, 0,    0, 0,    bba_pkg::ST_OK);
        // Zero total: nothing to allocate, every free is out of range.
        plan_cfg(bba_pkg::REG_TOTAL_BLOCKS, 0);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OUT_OF_BLOCKS);
        plan_req(bba_pkg::MODE_FREE,  1,    1, 0,    bba_pkg::ST_OUT_OF_RANGE);
        plan_cfg(bba_pkg::REG_TOTAL_BLOCKS, 1);
        plan_req(bba_pkg::MODE_FREE,  0,    1, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OUT_OF_BLOCKS);
        plan_req(bba_pkg::MODE_FREE,  1,    1, 0,    bba_pkg::ST_OUT_OF_RANGE);
        // Reserved region covering everything.
        plan_cfg(bba_pkg::REG_TOTAL_BLOCKS, 4096);
        plan_cfg(bba_pkg::REG_RESERVED_BLOCKS, 4096);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OUT_OF_BLOCKS);
        plan_req(bba_pkg::MODE_FREE,  4095, 1, 0,    bba_pkg::ST_OUT_OF_RANGE);
        plan_cfg(bba_pkg::REG_RESERVED_BLOCKS, 8191);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OUT_OF_BLOCKS);
        // Two blocks left at the very top of the map.
        plan_cfg(bba_pkg::REG_RESERVED_BLOCKS, 4094);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 4094, bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 4095, bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OUT_OF_BLOCKS);
        // Free of a used block inside the reserved region is refused.
        plan_req(bba_pkg::MODE_FREE,  1,    1, 0,    bba_pkg::ST_OUT_OF_RANGE);
        // Write past the register file must leave reserved at 4094.
        plan_cfg(REG_SPARE, 0);
        plan_req(bba_pkg::MODE_ALLOC, 0,    1, 0,    bba_pkg::ST_OUT_OF_BLOCKS);
        plan_req(bba_pkg::MODE_FREE,  4095, 1, 0,    bba_pkg::ST_OK);
        plan_cfg(bba_pkg::REG_RESERVED_BLOCKS, 0);
        plan_req(bba_pkg::MODE_ALLOC, 0,    0, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_FREE,  2,    0, 0,    bba_pkg::ST_OK);
        plan_req(bba_pkg::MODE_FREE,  2048, 0, 0,    bba_pkg::ST_OK);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG)
                write_reg(plan[k].reg_index, plan[k].reg_value);
            else
                offer(plan[k].req, plan[k].typed, plan[k].rsp);
        end

        // Fill four whole words from block 0, so later scans skip full words.
        run_phase(13'd256, 13'd0, 260, 95, 1'b1);
        // Drain with an odd reserved count; hold the response side off early on,
        // once the block is idle so the hold lands on fresh requests.
        write_reg(bba_pkg::REG_TOTAL_BLOCKS, 13'd130);
        write_reg(bba_pkg::REG_RESERVED_BLOCKS, 13'd7);
        hold_off_req = 1'b1;
        run_phase(13'd130, 13'd7, 220, 70, 1'b1);
        // Top two words of the map.
        run_phase(13'd4096, 13'd3968, 400, 95, 1'b1);
        run_phase(13'd8191, 13'd4030, 150, 80, 1'b1);
        tot = $urandom_range(1, 300);
        rsv = $urandom_range(0, tot);
        run_phase(tot[bba_pkg::REG_W-1:0], rsv[bba_pkg::REG_W-1:0], 200, 80, 1'b1);
        run_phase(13'd1, 13'd0, 50, 60, 1'b1);
        run_phase(13'd4096, 13'd4096, 30, 60, 1'b1);
        run_phase(13'd0, 13'd0, 30, 60, 1'b1);
        run_phase(13'd200, 13'd8191, 30, 60, 1'b1);
        tot = $urandom_range(2, 120);
        rsv = $urandom_range(0, 10);
        run_phase(tot[bba_pkg::REG_W-1:0], rsv[bba_pkg::REG_W-1:0], 200, 80, 1'b1);
        // Closing stretch at full rate on both sides.
        run_phase(13'd100, 13'd0, 250, 75, 1'b0);

        s_valid <= 1'b0;
        while (due_rsp_q.size() != 0 || typed_rsp_q.size() != 0) @(posedge aclk);
        // Let any stray response surface before closing out.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
